@@ src/sktab_pkg.sv @@
// Shared types and constants for the string key count table.
// Used by sktab_hash and string_key_count_hash_table; depends on nothing.
`default_nettype none
package sktab_pkg;
   localparam int BUCKET_BITS = 12;
   localparam int ENTRY_BITS  = 12;
   localparam int ENTRIES     = 4096;
   localparam int MAX_KEY_LEN = 49;
   localparam int LEN_W       = 6;
   localparam int USED_W      = ENTRY_BITS + 1;
   localparam int PART_W      = 4;
   localparam logic [BUCKET_BITS-1:0] HASH_SEED = BUCKET_BITS'(5381);

   typedef logic [2:0] status_type;
   localparam status_type STATUS_UPDATED   = 3'd0;
   localparam status_type STATUS_INSERTED  = 3'd1;
   localparam status_type STATUS_NOT_FOUND = 3'd2;
   localparam status_type STATUS_POOL_FULL = 3'd3;
   localparam status_type STATUS_TOO_LONG  = 3'd4;

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_FIND = 1'b1;

   typedef enum logic [12:0] {
      S_CLEAR  = 13'b0000000000001,
      S_IDLE   = 13'b0000000000010,
      S_HREAD  = 13'b0000000000100,
      S_HCHK   = 13'b0000000001000,
      S_EREAD  = 13'b0000000010000,
      S_ECHK   = 13'b0000000100000,
      S_CMPRD  = 13'b0000001000000,
      S_CMP    = 13'b0000010000000,
      S_HIT    = 13'b0000100000000,
      S_MISS   = 13'b0001000000000,
      S_COPYRD = 13'b0010000000000,
      S_COPYWR = 13'b0100000000000,
      S_OUT    = 13'b1000000000000
   } state_type;
endpackage
`default_nettype wire

@@ src/sktab_hash.sv @@
// One djb2 step (hash * 33 + signed byte) on the low hash bits.
// Depends on sktab_pkg.
`default_nettype none
module sktab_hash (
   input  wire logic [sktab_pkg::BUCKET_BITS-1:0] hash_cur,
   input  wire logic [7:0]                         key_byte,
   output      logic [sktab_pkg::BUCKET_BITS-1:0] hash_next
);
   logic [sktab_pkg::BUCKET_BITS-1:0] sext;
   always_comb begin
      sext = sktab_pkg::BUCKET_BITS'($signed(key_byte));
      hash_next = (hash_cur << 5) + hash_cur + sext;
   end
endmodule
`default_nettype wire

@@ src/string_key_count_hash_table.sv @@
// String key count table: djb2 hash, chained buckets, fixed entry pool.
// Depends on sktab_pkg and sktab_hash.
//
// Keys arrive one byte per transfer. On the final byte the block stops taking
// transfers, reads the bucket head, then walks the chain: per entry it reads
// and checks the length (S_EREAD, S_ECHK), per byte it reads and compares
// (S_CMPRD, S_CMP) through the single byte comparator. A hit passes S_HIT, an
// insert copies the key bytes (S_COPYRD, S_COPYWR), then the result waits in
// its output register until taken. After reset a clearing pass empties the
// bucket table; no request is taken meanwhile.
`default_nettype none
module string_key_count_hash_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_key_byte,
   input  wire logic        req_key_last,
   input  wire logic [31:0] req_add_value,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [2:0]  rsp_status,
   output      logic [31:0] rsp_count_value,
   output      logic [3:0]  rsp_partition
);
   localparam int BB = sktab_pkg::BUCKET_BITS;
   localparam int EB = sktab_pkg::ENTRY_BITS;
   localparam int LW = sktab_pkg::LEN_W;
   localparam int UW = sktab_pkg::USED_W;

   sktab_pkg::state_type state_ff, state_in;
   logic [BB-1:0] hash_ff, hash_in, hash_step;
   logic [LW-1:0] len_ff, len_in, klen_ff, klen_in, idx_ff, idx_in;
   logic          long_ff, long_in;
   logic [BB-1:0] bucket_ff, bucket_in, clr_ff, clr_in;
   logic [EB-1:0] e_ff, e_in;
   logic [UW-1:0] used_ff, used_in;
   logic          req_ff, req_in;
   logic [31:0]   addv_ff, addv_in;
   logic [2:0]    status_ff, status_in;
   logic [31:0]   count_ff, count_in;
   logic [3:0]    part_ff, part_in;

   // memories and their registered read data
   logic [7:0]     kbuf_mem [0:sktab_pkg::MAX_KEY_LEN-1];
   logic [EB:0]    bucket_mem [0:(1<<BB)-1];
   logic [LW+EB:0] meta_mem [0:sktab_pkg::ENTRIES-1];
   logic [31:0]    cnt_mem [0:sktab_pkg::ENTRIES-1];
   logic [7:0]     ebyte_mem [0:(1<<(EB+LW))-1];
   logic [7:0]     kbuf_rd_ff, ebyte_rd_ff;
   logic [EB:0]    bucket_rd_ff;
   logic [LW+EB:0] meta_rd_ff;
   logic [31:0]    cnt_rd_ff;

   logic          acc, too_long_now;
   logic          bk_we, meta_we, cnt_we, eb_we;
   logic [BB-1:0] bk_wa;
   logic [EB:0]   bk_wd;
   logic [EB-1:0] cnt_wa;
   logic [31:0]   cnt_wd;
   logic [LW-1:0] m_len;
   logic          m_lv;
   logic [EB-1:0] m_link;

   sktab_hash u_hash (.hash_cur(hash_ff), .key_byte(req_key_byte), .hash_next(hash_step));

   assign req_stall       = (state_ff != sktab_pkg::S_IDLE);
   assign acc             = req_valid && !req_stall;
   assign rsp_valid       = (state_ff == sktab_pkg::S_OUT);
   assign rsp_status      = status_ff;
   assign rsp_count_value = count_ff;
   assign rsp_partition   = part_ff;
   assign too_long_now    = long_ff || (len_ff == LW'(sktab_pkg::MAX_KEY_LEN));
   assign {m_len, m_lv, m_link} = meta_rd_ff;

   always_comb begin
      state_in  = state_ff;
      hash_in   = hash_ff;
      len_in    = len_ff;
      klen_in   = klen_ff;
      idx_in    = idx_ff;
      long_in   = long_ff;
      bucket_in = bucket_ff;
      clr_in    = clr_ff;
      e_in      = e_ff;
      used_in   = used_ff;
      req_in    = req_ff;
      addv_in   = addv_ff;
      status_in = status_ff;
      count_in  = count_ff;
      part_in   = part_ff;
      bk_we     = 1'b0;
      bk_wa     = clr_ff;
      bk_wd     = '0;
      meta_we   = 1'b0;
      cnt_we    = 1'b0;
      cnt_wa    = e_ff;
      cnt_wd    = addv_ff;
      eb_we     = 1'b0;
      case (state_ff)
         sktab_pkg::S_CLEAR: begin
            // empty one bucket a cycle
            bk_we  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = sktab_pkg::S_IDLE;
            end
         end
         sktab_pkg::S_IDLE: begin
            if (acc) begin
               hash_in = hash_step;
               if (too_long_now) begin
                  long_in = 1'b1;
               end else begin
                  len_in = len_ff + 1'b1;
               end
               if (req_key_last) begin
                  klen_in   = too_long_now ? len_ff : len_ff + 1'b1;
                  bucket_in = hash_step;
                  part_in   = hash_step[3:0];
                  req_in    = req_type;
                  addv_in   = req_add_value;
                  hash_in   = sktab_pkg::HASH_SEED;
                  len_in    = '0;
                  long_in   = 1'b0;
                  if (too_long_now) begin
                     status_in = sktab_pkg::STATUS_TOO_LONG;
                     count_in  = '0;
                     state_in  = sktab_pkg::S_OUT;
                  end else begin
                     state_in  = sktab_pkg::S_HREAD;
                  end
               end
            end
         end
         sktab_pkg::S_HREAD: state_in = sktab_pkg::S_HCHK;
         sktab_pkg::S_HCHK: begin
            if (bucket_rd_ff[EB]) begin
               e_in     = bucket_rd_ff[EB-1:0];
               state_in = sktab_pkg::S_EREAD;
            end else begin
               state_in = sktab_pkg::S_MISS;
            end
         end
         sktab_pkg::S_EREAD: state_in = sktab_pkg::S_ECHK;
         sktab_pkg::S_ECHK: begin
            idx_in = '0;
            if (m_len == klen_ff) begin
               state_in = sktab_pkg::S_CMPRD;
            end else if (m_lv) begin
               e_in     = m_link;
               state_in = sktab_pkg::S_EREAD;
            end else begin
               state_in = sktab_pkg::S_MISS;
            end
         end
         sktab_pkg::S_CMPRD: state_in = sktab_pkg::S_CMP;
         sktab_pkg::S_CMP: begin
            if (kbuf_rd_ff != ebyte_rd_ff) begin
               // advance along the chain
               if (m_lv) begin
                  e_in     = m_link;
                  state_in = sktab_pkg::S_EREAD;
               end else begin
                  state_in = sktab_pkg::S_MISS;
               end
            end else if (idx_ff == klen_ff - 1'b1) begin
               state_in = sktab_pkg::S_HIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = sktab_pkg::S_CMPRD;
            end
         end
         sktab_pkg::S_HIT: begin
            status_in = sktab_pkg::STATUS_UPDATED;
            if (req_ff == sktab_pkg::REQ_ADD) begin
               cnt_we   = 1'b1;
               cnt_wd   = cnt_rd_ff + addv_ff;
               count_in = cnt_rd_ff + addv_ff;
            end else begin
               count_in = cnt_rd_ff;
            end
            state_in = sktab_pkg::S_OUT;
         end
         sktab_pkg::S_MISS: begin
            count_in = '0;
            state_in = sktab_pkg::S_OUT;
            if (req_ff == sktab_pkg::REQ_FIND) begin
               status_in = sktab_pkg::STATUS_NOT_FOUND;
            end else if (used_ff == UW'(sktab_pkg::ENTRIES)) begin
               status_in = sktab_pkg::STATUS_POOL_FULL;
            end else begin
               // link the new entry at the chain head, then copy its bytes
               status_in = sktab_pkg::STATUS_INSERTED;
               count_in  = addv_ff;
               e_in      = used_ff[EB-1:0];
               used_in   = used_ff + 1'b1;
               idx_in    = '0;
               meta_we   = 1'b1;
               cnt_we    = 1'b1;
               cnt_wa    = used_ff[EB-1:0];
               bk_we     = 1'b1;
               bk_wa     = bucket_ff;
               bk_wd     = {1'b1, used_ff[EB-1:0]};
               state_in  = sktab_pkg::S_COPYRD;
            end
         end
         sktab_pkg::S_COPYRD: state_in = sktab_pkg::S_COPYWR;
         sktab_pkg::S_COPYWR: begin
            eb_we  = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == klen_ff - 1'b1) begin
               state_in = sktab_pkg::S_OUT;
            end else begin
               state_in = sktab_pkg::S_COPYRD;
            end
         end
         sktab_pkg::S_OUT: begin
            if (!rsp_stall) begin
               state_in = sktab_pkg::S_IDLE;
            end
         end
         default: state_in = sktab_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sktab_pkg::S_CLEAR;
         hash_ff  <= sktab_pkg::HASH_SEED;
         len_ff   <= '0;
         long_ff  <= 1'b0;
         clr_ff   <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         len_ff   <= len_in;
         long_ff  <= long_in;
         clr_ff   <= clr_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      klen_ff   <= klen_in;
      idx_ff    <= idx_in;
      bucket_ff <= bucket_in;
      e_ff      <= e_in;
      req_ff    <= req_in;
      addv_ff   <= addv_in;
      status_ff <= status_in;
      count_ff  <= count_in;
      part_ff   <= part_in;
   end

   always_ff @(posedge clock) begin
      if (acc && !too_long_now) begin
         kbuf_mem[len_ff] <= req_key_byte;
      end
      kbuf_rd_ff <= kbuf_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (bk_we) begin
         bucket_mem[bk_wa] <= bk_wd;
      end
      bucket_rd_ff <= bucket_mem[bucket_ff];
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[used_ff[EB-1:0]] <= {klen_ff, bucket_rd_ff};
      end
      meta_rd_ff <= meta_mem[e_ff];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      cnt_rd_ff <= cnt_mem[e_ff];
   end

   always_ff @(posedge clock) begin
      if (eb_we) begin
         ebyte_mem[{e_ff, idx_ff}] <= kbuf_rd_ff;
      end
      ebyte_rd_ff <= ebyte_mem[{e_ff, idx_ff}];
   end

   a_no_take_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while a result waits");
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(sktab_pkg::ENTRIES)) else $error("entry pool overrun");
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sktab_pkg::STATUS_INSERTED |-> rsp_count_value == addv_ff)
      else $error("inserted count differs from add value");
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_count_value))
      else $error("stalled result changed");
endmodule
`default_nettype wire
